// ===== src/srpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

    // Field and register widths.
    localparam int REG_W      = 20;
    localparam int CNT_W      = 20;
    localparam int DIV_CNT_W  = $clog2(REG_W);
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = ((REG_W + 7) / 8) * 8;
    localparam int M_RES_W    = 2 + CNT_W;
    localparam int M_TDATA_W  = ((M_RES_W + 7) / 8) * 8;

    // Last step of the shift-subtract divider.
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(REG_W - 1);

    // Register reset values.
    localparam logic [REG_W-1:0] TICK_RATE_RST = REG_W'(1000000);
    localparam logic [REG_W-1:0] FREQ_MAX_RST  = REG_W'(20000);
    localparam logic [REG_W-1:0] FREQ_MIN_RST  = REG_W'(16);
    localparam logic [CNT_W-1:0] PERIOD_RST    = CNT_W'(999);
    localparam logic [CNT_W-1:0] COMPARE_RST   = CNT_W'(500);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN  = CFG_IDX_W'(2);

    // Command codes carried on tuser.
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET_FREQ = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } srpg_state_t;

endpackage

`default_nettype wire

// ===== src/step_rate_pulse_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (low bit up)                          tuser
// s_        input      freq[19:0], zero pad to 24 bits             cmd
// m_        output     step_level, running, period_in_use[19:0],   none
//                      zero pad to 24 bits
//
// A tick item, a stop, or a frequency equal to the current one is answered straight from idle.
// A frequency that changes the period is accepted and clamped, runs through the
// one-bit-per-cycle restoring divider, then loads the result once the output is free.
// Reset is synchronous and active low; no clearing pass is needed.
// The input is not ready while the divider runs or while the output register
// holds an item that is not being taken.

module step_rate_pulse_generator_core
    import srpg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // freq[19:0], pad
    input  wire logic                  s_tuser,   // cmd

    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata,   // step_level, running, period_in_use, pad

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [REG_W-1:0]      cfg_wdata
);

    // Configuration registers.
    logic [REG_W-1:0] tick_rate_reg;
    logic [REG_W-1:0] freq_max_reg;
    logic [REG_W-1:0] freq_min_reg;

    // Timer state.
    logic [CNT_W-1:0] tick_count_reg,      tick_count_next;
    logic [CNT_W-1:0] active_period_reg,   active_period_next;
    logic [CNT_W-1:0] active_compare_reg,  active_compare_next;
    logic [CNT_W-1:0] pending_period_reg,  pending_period_next;
    logic [CNT_W-1:0] pending_compare_reg, pending_compare_next;
    logic [REG_W-1:0] cur_freq_reg,        cur_freq_next;
    logic             enabled_reg,         enabled_next;

    // Sequencer and divider.
    srpg_state_t          state_reg, state_next;
    logic [REG_W-1:0]     div_freq_reg, div_freq_next;
    logic [REG_W-1:0]     rem_reg, rem_next;
    logic [REG_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    // Output register.
    logic             m_tvalid_reg, m_tvalid_next;
    logic             step_level_reg;
    logic             running_reg;
    logic [CNT_W-1:0] period_out_reg;

    logic             out_free;
    logic             accept;
    logic             res_load;
    logic [REG_W-1:0] in_freq;
    logic [REG_W-1:0] f_hi;
    logic [REG_W-1:0] f_lo;
    logic [REG_W-1:0] f_clamp;
    logic [REG_W:0]   partial;
    logic             sub_ok;
    logic [CNT_W-1:0] new_period;
    logic [CNT_W-1:0] new_compare;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign in_freq  = s_tdata[REG_W-1:0];

    // Clamp the requested frequency: the lower bound is applied last, zero becomes 1 Hz.
    always_comb begin
        f_hi    = (in_freq > freq_max_reg) ? freq_max_reg : in_freq;
        f_lo    = (f_hi < freq_min_reg) ? freq_min_reg : f_hi;
        f_clamp = (f_lo == '0) ? REG_W'(1) : f_lo;
    end

    // One restoring division step: shift in a dividend bit and try to subtract.
    always_comb begin
        partial = {rem_reg, quo_reg[REG_W-1]};
        sub_ok  = partial >= {1'b0, div_freq_reg};
    end

    // Period is quotient minus one, saturating at zero; compare is (period + 1) / 2.
    always_comb begin
        new_period  = (quo_reg == '0) ? '0 : CNT_W'(quo_reg - REG_W'(1));
        new_compare = CNT_W'(quo_reg >> 1);
    end

    // Sequencer: next state, timer updates and result load.
    always_comb begin
        state_next           = state_reg;
        tick_count_next      = tick_count_reg;
        active_period_next   = active_period_reg;
        active_compare_next  = active_compare_reg;
        pending_period_next  = pending_period_reg;
        pending_compare_next = pending_compare_reg;
        cur_freq_next        = cur_freq_reg;
        enabled_next         = enabled_reg;
        div_freq_next        = div_freq_reg;
        rem_next             = rem_reg;
        quo_next             = quo_reg;
        step_next            = step_reg;
        res_load             = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_TICK) begin
                        res_load = 1'b1;
                        if (enabled_reg) begin
                            if (tick_count_reg >= active_period_reg) begin
                                tick_count_next     = '0;
                                active_period_next  = pending_period_reg;
                                active_compare_next = pending_compare_reg;
                            end else begin
                                tick_count_next = tick_count_reg + CNT_W'(1);
                            end
                        end
                    end else if (in_freq == '0) begin
                        res_load        = 1'b1;
                        enabled_next    = 1'b0;
                        tick_count_next = '0;
                        cur_freq_next   = '0;
                    end else if (f_clamp == cur_freq_reg) begin
                        res_load = 1'b1;
                    end else begin
                        div_freq_next = f_clamp;
                        rem_next      = '0;
                        quo_next      = tick_rate_reg;
                        step_next     = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = sub_ok ? REG_W'(partial - {1'b0, div_freq_reg})
                                   : partial[REG_W-1:0];
                quo_next  = {quo_reg[REG_W-2:0], sub_ok};
                step_next = step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_load             = 1'b1;
                    pending_period_next  = new_period;
                    pending_compare_next = new_compare;
                    if ((cur_freq_reg == '0) || !enabled_reg) begin
                        tick_count_next     = '0;
                        active_period_next  = new_period;
                        active_compare_next = new_compare;
                        enabled_next        = 1'b1;
                    end
                    cur_freq_next = div_freq_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control and timer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            tick_count_reg      <= '0;
            active_period_reg   <= PERIOD_RST;
            active_compare_reg  <= COMPARE_RST;
            pending_period_reg  <= PERIOD_RST;
            pending_compare_reg <= COMPARE_RST;
            cur_freq_reg        <= '0;
            enabled_reg         <= 1'b0;
            m_tvalid_reg        <= 1'b0;
        end else begin
            state_reg           <= state_next;
            tick_count_reg      <= tick_count_next;
            active_period_reg   <= active_period_next;
            active_compare_reg  <= active_compare_next;
            pending_period_reg  <= pending_period_next;
            pending_compare_reg <= pending_compare_next;
            cur_freq_reg        <= cur_freq_next;
            enabled_reg         <= enabled_next;
            m_tvalid_reg        <= m_tvalid_next;
        end
    end

    // Divider datapath registers.
    always_ff @(posedge aclk) begin
        div_freq_reg <= div_freq_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
    end

    // Result payload, taken from the updated timer state.
    always_ff @(posedge aclk) begin
        if (res_load) begin
            step_level_reg <= enabled_next && (tick_count_next < active_compare_next);
            running_reg    <= enabled_next;
            period_out_reg <= active_period_next;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= TICK_RATE_RST;
            freq_max_reg  <= FREQ_MAX_RST;
            freq_min_reg  <= FREQ_MIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TICK_RATE: tick_rate_reg <= cfg_wdata;
                CFG_FREQ_MAX:  freq_max_reg  <= cfg_wdata;
                CFG_FREQ_MIN:  freq_min_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_RES_W){1'b0}}, period_out_reg, running_reg,
                       step_level_reg};

endmodule

`default_nettype wire
